>>> design/ppc_pkg.sv
// Package for the position PID controller: field widths, register indexes,
// reset values and the stage enable bundle. No dependencies.
`default_nettype none

package ppc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_OUT_LIMIT   = 3'd3,
    CFG_INVERT      = 3'd4,
    CFG_INT_WINDOW  = 3'd5,
    CFG_DEADZONE    = 3'd6
  } cfg_reg_t;

  // Field and datapath widths
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int WINDOW_W  = 16;
  localparam int DZ_W      = 16;
  localparam int DRIVE_W   = 16;
  localparam int ERR_W     = POS_W + 1;        // target minus (possibly negated) position
  localparam int DER_W     = ERR_W + 1;
  localparam int INTEG_W   = 17;
  localparam int PP_W      = GAIN_W + ERR_W;
  localparam int PI_W      = GAIN_W + INTEG_W;
  localparam int PD_W      = GAIN_W + DER_W;
  localparam int ACC_W     = PD_W + 2;

  // Request kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  // Reset values
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd255;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd1000;

  // Load enables for the back end stages
  typedef struct packed {
    logic en3;
    logic en4;
    logic eno;
  } ppc_stage_en_t;

endpackage

`default_nettype wire

>>> design/ppc_mac.sv
// Back end of the position PID controller: gain products, sum, truncation
// toward zero and drive saturation. Depends on ppc_pkg.
`default_nettype none

module ppc_mac
  import ppc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire                        clk,
  input  wire ppc_stage_en_t         stage_en,
  input  wire logic signed [GAIN_W-1:0]  gain_p,
  input  wire logic signed [GAIN_W-1:0]  gain_i,
  input  wire logic signed [GAIN_W-1:0]  gain_d,
  input  wire logic [LIMIT_W-1:0]        out_limit,
  input  wire logic signed [ERR_W-1:0]   err,
  input  wire logic signed [INTEG_W-1:0] integ,
  input  wire logic signed [DER_W-1:0]   der,
  input  wire logic                      at_target,
  output logic signed [DRIVE_W-1:0]      drive,
  output logic                           drive_at_target
);

  logic signed [PP_W-1:0]    pp_r, pp_nxt;
  logic signed [PI_W-1:0]    pi_r, pi_nxt;
  logic signed [PD_W-1:0]    pd_r, pd_nxt;
  logic                      at3_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      at4_r;
  logic signed [ACC_W-1:0]   acc_biased;
  logic signed [ACC_W-1:0]   quot;
  logic signed [ACC_W-1:0]   lim_pos;
  logic signed [ACC_W-1:0]   lim_neg;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic                      ato_r;

  // Stage 3: one multiply per term
  always_comb begin
    pp_nxt = gain_p * err;
    pi_nxt = gain_i * integ;
    pd_nxt = gain_d * der;
  end

  always_ff @(posedge clk) begin
    if (stage_en.en3) begin
      pp_r  <= pp_nxt;
      pi_r  <= pi_nxt;
      pd_r  <= pd_nxt;
      at3_r <= at_target;
    end
  end

  // Stage 4: sum of the three terms
  assign acc_nxt = ACC_W'(pp_r) + ACC_W'(pi_r) + ACC_W'(pd_r);

  always_ff @(posedge clk) begin
    if (stage_en.en4) begin
      acc_r <= acc_nxt;
      at4_r <= at3_r;
    end
  end

  // Output stage: truncate toward zero (bias negatives before the shift), then saturate
  always_comb begin
    acc_biased = acc_r + $signed({{(ACC_W-GAIN_FRAC_BITS){1'b0}},
                                  {GAIN_FRAC_BITS{acc_r[ACC_W-1]}}});
    quot       = acc_biased >>> GAIN_FRAC_BITS;
    lim_pos    = $signed({{(ACC_W-LIMIT_W){1'b0}}, out_limit});
    lim_neg    = -lim_pos;
    if (quot > lim_pos) begin
      drive_nxt = lim_pos[DRIVE_W-1:0];
    end else if (quot < lim_neg) begin
      drive_nxt = lim_neg[DRIVE_W-1:0];
    end else begin
      drive_nxt = quot[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en.eno) begin
      drive_r <= drive_nxt;
      ato_r   <= at4_r;
    end
  end

  assign drive           = drive_r;
  assign drive_at_target = ato_r;

endmodule

`default_nettype wire

>>> design/position_pid_controller.sv
// Position PID controller with integral anti-windup.
// A request passes the input register, then the stage 2, product, sum and drive registers.
// Throughput: one request per cycle while out_stall is low; the loop state (integral,
// last error) is updated in a single stage; multiplies, sum and saturation are pipelined.
// Reset (rst_n low, synchronous) empties the pipeline, clears the loop state and
// loads the register reset values. Depends on ppc_pkg and ppc_mac.
`default_nettype none

module position_pid_controller
  import ppc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
  // requests
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_kind,
  input  wire logic signed [POS_W-1:0]   in_position,
  input  wire logic signed [POS_W-1:0]   in_target,
  // results
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DRIVE_W-1:0]      out_drive,
  output logic                           out_at_target
);

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_W-1:0]       limit_r;
  logic                     invert_r;
  logic [WINDOW_W-1:0]      window_r;
  logic [DZ_W-1:0]          deadzone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      limit_r    <= LIMIT_RST;
      invert_r   <= 1'b0;
      window_r   <= WINDOW_RST;
      deadzone_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GAIN_P:     gain_p_r   <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_I:     gain_i_r   <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_D:     gain_d_r   <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_OUT_LIMIT:  limit_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_INVERT:     invert_r   <= cfg_wdata[0];
        CFG_INT_WINDOW: window_r   <= cfg_wdata[WINDOW_W-1:0];
        CFG_DEADZONE:   deadzone_r <= cfg_wdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and stage enables
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic en1, en2;
  ppc_stage_en_t stage_en;

  always_comb begin
    stage_en.eno = !vo_r || !out_stall;
    stage_en.en4 = !v4_r || stage_en.eno;
    stage_en.en3 = !v3_r || stage_en.en4;
    en2          = !v2_r || stage_en.en3;
    en1          = !v1_r || en2;
  end

  assign in_stall  = !en1;
  assign out_valid = vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)          v1_r <= in_valid;
      if (en2)          v2_r <= v1_r;
      if (stage_en.en3) v3_r <= v2_r;
      if (stage_en.en4) v4_r <= v3_r;
      if (stage_en.eno) vo_r <= v4_r;
    end
  end

  // Stage 1: input register
  logic                     kind_r;
  logic signed [POS_W-1:0]  pos_r, tgt_r;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      tgt_r  <= in_target;
    end
  end

  // Loop state
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, prev_err_nxt;

  // Error, integral, derivative and deadzone test
  logic                      is_stop;
  logic signed [ERR_W-1:0]   raw_ext;
  logic signed [ERR_W-1:0]   pos_eff;
  logic signed [DER_W-1:0]   err_wide;
  logic signed [ERR_W-1:0]   err;
  logic signed [DER_W-1:0]   win_s;
  logic                      in_window;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W:0]   ilim;
  logic signed [INTEG_W:0]   iclamp;
  logic signed [DER_W-1:0]   der;
  logic signed [ERR_W-1:0]   raw_err;
  logic signed [ERR_W-1:0]   dz_s;
  logic                      at_tgt;

  always_comb begin
    is_stop  = (kind_r == KIND_STOP);
    raw_ext  = ERR_W'(pos_r);
    pos_eff  = invert_r ? -raw_ext : raw_ext;
    err_wide = DER_W'(tgt_r) - DER_W'(pos_eff);
    err      = err_wide[ERR_W-1:0];

    win_s     = $signed({{(DER_W-WINDOW_W){1'b0}}, window_r});
    in_window = (err_wide < win_s) && (err_wide > -win_s);

    // Only meaningful inside the window, where the error fits the narrow add
    isum = (INTEG_W+1)'(integ_r) + $signed(err[INTEG_W:0]);
    ilim = $signed({2'b00, limit_r, 1'b0});
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end

    if (is_stop || !in_window) begin
      integ_nxt = '0;
    end else begin
      integ_nxt = iclamp[INTEG_W-1:0];
    end

    der          = DER_W'(err) - DER_W'(prev_err_r);
    prev_err_nxt = is_stop ? '0 : err;

    // Deadzone always looks at the raw position
    raw_err = ERR_W'(tgt_r) - ERR_W'(pos_r);
    dz_s    = $signed({{(ERR_W-DZ_W){1'b0}}, deadzone_r});
    at_tgt  = is_stop || ((raw_err <= dz_s) && (raw_err >= -dz_s));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else if (v1_r && en2) begin
      integ_r    <= integ_nxt;
      prev_err_r <= prev_err_nxt;
    end
  end

  // Stage 2: terms for the multiplies; a stop zeroes them so the drive is zero
  logic signed [ERR_W-1:0]   e2_r;
  logic signed [INTEG_W-1:0] i2_r;
  logic signed [DER_W-1:0]   d2_r;
  logic                      at2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      e2_r  <= is_stop ? '0 : err;
      i2_r  <= integ_nxt;
      d2_r  <= is_stop ? '0 : der;
      at2_r <= at_tgt;
    end
  end

  ppc_mac #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk             (clk),
    .stage_en        (stage_en),
    .gain_p          (gain_p_r),
    .gain_i          (gain_i_r),
    .gain_d          (gain_d_r),
    .out_limit       (limit_r),
    .err             (e2_r),
    .integ           (i2_r),
    .der             (d2_r),
    .at_target       (at2_r),
    .drive           (out_drive),
    .drive_at_target (out_at_target)
  );

`ifndef SYNTHESIS
  // A stop request leaves the loop state cleared
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2 && kind_r == KIND_STOP) |=> (integ_r == '0 && prev_err_r == '0))
    else $error("loop state not cleared by stop");

  // Stall only when the input register is occupied and cannot drain
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && vo_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A full back end under a stalled output keeps its item
  a_hold_stage4: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && vo_r && out_stall) |=> v4_r)
    else $error("stage 4 item dropped under stall");

  // Loop state only moves when a request leaves stage 1
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && en2) |=> ($stable(integ_r) && $stable(prev_err_r)))
    else $error("loop state changed without a request");
`endif

endmodule

`default_nettype wire

>>> dv/tb_position_pid_controller.sv
// Self-checking testbench for position_pid_controller: a directed table, then
// random control sequences under random idling on both channels. Needs ppc_pkg.
`default_nettype none

module tb_position_pid_controller;
  import ppc_pkg::*;

  localparam int FRAC       = 8;
  localparam int LAT_PAUSE  = 8;
  localparam int CYCLE_CAP  = 300000;
  localparam int PRINT_CAP  = 100;
  localparam int PHASES     = 10;
  localparam int PHASE_REQS = 65;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      at_target;
  } pid_out_t;

  typedef struct packed {
    logic     typed;
    pid_out_t want;
  } typed_tag_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  kind;
    logic [POS_W-1:0]      position;
    logic [POS_W-1:0]      target;
    logic                  typed;
    pid_out_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [POS_W-1:0]      in_position;
  logic [POS_W-1:0]      in_target;
  logic                  out_valid;
  logic                  out_stall;
  logic [DRIVE_W-1:0]    out_drive;
  logic                  out_at_target;

  // Predictor copy of the registers and loop state
  longint kp = 0, ki = 0, kd = 0;
  longint lim = longint'(LIMIT_RST);
  longint win = longint'(WINDOW_RST);
  longint dz = 0;
  bit     inv = 1'b0;
  longint integ_sum = 0;
  longint last_err = 0;

  pid_out_t   pid_result_q[$];
  typed_tag_t typed_q[$];
  stim_row_t  dir_rows[$];

  int errors = 0;
  int cyc = 0;
  int stall_left = 0;
  bit stall_on = 1'b0;
  bit gap_on = 1'b0;

  position_pid_controller #(.GAIN_FRAC_BITS(FRAC)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_target    (in_target),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive    (out_drive),
    .out_at_target(out_at_target)
  );

  always #4 clk = ~clk;

  function automatic longint clamp_mag(longint v, longint bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  function automatic void load_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    case (r)
      CFG_GAIN_P:     kp = longint'($signed(v));
      CFG_GAIN_I:     ki = longint'($signed(v));
      CFG_GAIN_D:     kd = longint'($signed(v));
      CFG_OUT_LIMIT:  lim = longint'(v[LIMIT_W-1:0]);
      CFG_INVERT:     inv = v[0];
      CFG_INT_WINDOW: win = longint'(v);
      CFG_DEADZONE:   dz = longint'(v);
      default: ;
    endcase
  endfunction

  function automatic pid_out_t pid_predict(logic kind, logic signed [POS_W-1:0] pos,
                                           logic signed [POS_W-1:0] tgt);
    pid_out_t res;
    longint   meas, err, der, acc, drv, raw_err;
    if (kind == KIND_STOP) begin
      integ_sum = 0;
      last_err = 0;
      res.drive = '0;
      res.at_target = 1'b1;
      return res;
    end
    meas = inv ? -longint'(pos) : longint'(pos);
    err = longint'(tgt) - meas;
    // integrate only inside the window, otherwise drop the integral
    if (err < win && err > -win) integ_sum = clamp_mag(integ_sum + err, lim * 2);
    else integ_sum = 0;
    der = err - last_err;
    last_err = err;
    acc = kp * err + ki * integ_sum + kd * der;
    acc = acc / (longint'(1) << FRAC);
    drv = clamp_mag(acc, lim);
    raw_err = longint'(tgt) - longint'(pos);
    res.drive = drv[DRIVE_W-1:0];
    res.at_target = (raw_err <= dz && raw_err >= -dz);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cyc, what);
  endtask

  // Results are checked before the request accepted at the same edge is queued
  always @(posedge clk) begin : result_check
    pid_out_t   want;
    pid_out_t   hit;
    typed_tag_t tag;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pid_result_q.size() == 0) begin
          flag_mismatch("result with no request pending");
        end else begin
          want = pid_result_q.pop_front();
          if (out_drive !== want.drive)
            flag_mismatch($sformatf("drive %0d, expected %0d",
                                    $signed(out_drive), $signed(want.drive)));
          if (out_at_target !== want.at_target)
            flag_mismatch($sformatf("at_target %b, expected %b",
                                    out_at_target, want.at_target));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        hit = pid_predict(in_kind, in_position, in_target);
        tag = typed_q.pop_front();
        pid_result_q.push_back(tag.typed ? tag.want : hit);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_CAP) begin
      $display("tb_position_pid_controller: done, errors");
      $finish;
    end
  end

  function automatic stim_row_t item_row(logic kind, logic [POS_W-1:0] pos,
                                         logic [POS_W-1:0] tgt);
    stim_row_t row;
    row = '0;
    row.reg_sel = CFG_GAIN_P;
    row.kind = kind;
    row.position = pos;
    row.target = tgt;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic kind, logic [POS_W-1:0] pos,
                                          logic [POS_W-1:0] tgt, logic at);
    stim_row_t row;
    row = item_row(kind, pos, tgt);
    row.typed = 1'b1;
    row.want.drive = '0;
    row.want.at_target = at;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = r;
    row.value = v;
    return row;
  endfunction

  task automatic send(logic kind, logic [POS_W-1:0] pos, logic [POS_W-1:0] tgt,
                      logic typed, pid_out_t want);
    typed_tag_t tag;
    tag.typed = typed;
    tag.want = want;
    if (gap_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    typed_q.push_back(tag);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_position <= pos;
    in_target <= tgt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pid_result_q.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    load_reg(r, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 1024)) - CFG_DATA_W'(512);
  endfunction

  task automatic run_phase(int n, bit quiet);
    logic signed [POS_W-1:0] pos, tgt, track, err;
    int span, pick;
    settle();
    write_reg(CFG_GAIN_P, rand_gain());
    write_reg(CFG_GAIN_I, rand_gain());
    write_reg(CFG_GAIN_D, rand_gain());
    write_reg(CFG_OUT_LIMIT, CFG_DATA_W'(($urandom_range(0, 2) == 0)
                                         ? $urandom_range(1, 32767)
                                         : $urandom_range(1, 400)));
    write_reg(CFG_INVERT, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(CFG_INT_WINDOW, CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 65535)
                                          : $urandom_range(50, 3000)));
    write_reg(CFG_DEADZONE, CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                        ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 20)));
    stall_on <= quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    gap_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    track = $urandom;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send(KIND_STOP, $urandom, $urandom, 1'b0, '0);
      end else if (pick < 15) begin
        send(KIND_STEP, $urandom, $urandom, 1'b0, '0);
      end else begin
        // follow a drifting target with a small tracking error
        if ($urandom_range(0, 30) == 0) track = $urandom;
        else track = track + $signed($urandom_range(0, 200)) - 100;
        case ($urandom_range(0, 3))
          0: span = 3;
          1: span = 300;
          2: span = 2000;
          default: span = 100000;
        endcase
        err = $signed($urandom_range(0, 2 * span)) - span;
        tgt = track;
        pos = tgt - err;
        if (inv) pos = -pos;
        send(KIND_STEP, pos, tgt, 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    bit busy;
    busy = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_STEP;
    in_position = '0;
    in_target = '0;
    out_stall = 1'b0;

    // Reset registers: all gains zero, so drive stays zero
    dir_rows.push_back(typed_row(KIND_STEP, 32'h0000_0000, 32'h0000_0000, 1'b1));
    dir_rows.push_back(typed_row(KIND_STEP, 32'h7fff_ffff, 32'h8000_0000, 1'b0));
    dir_rows.push_back(typed_row(KIND_STEP, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
    dir_rows.push_back(typed_row(KIND_STOP, 32'hffff_ffff, 32'h1234_5678, 1'b1));
    dir_rows.push_back(typed_row(KIND_STEP, -32'sd5, -32'sd5, 1'b1));
    dir_rows.push_back(typed_row(KIND_STEP, 32'd1000, 32'd999, 1'b0));
    // Inverted position, widest limit, window and deadzone
    dir_rows.push_back(cfg_row(CFG_GAIN_P, 16'h0100));
    dir_rows.push_back(cfg_row(CFG_GAIN_I, 16'h0020));
    dir_rows.push_back(cfg_row(CFG_GAIN_D, 16'hff80));
    dir_rows.push_back(cfg_row(CFG_OUT_LIMIT, 16'h7fff));
    dir_rows.push_back(cfg_row(CFG_INVERT, 16'h0001));
    dir_rows.push_back(cfg_row(CFG_INT_WINDOW, 16'hffff));
    dir_rows.push_back(cfg_row(CFG_DEADZONE, 16'hffff));
    dir_rows.push_back(item_row(KIND_STEP, 32'h8000_0000, 32'h0000_0000));
    dir_rows.push_back(item_row(KIND_STEP, 32'h7fff_ffff, 32'h8000_0000));
    dir_rows.push_back(item_row(KIND_STEP, -32'sd100, 32'd50));
    dir_rows.push_back(item_row(KIND_STEP, 32'd300, -32'sd250));
    dir_rows.push_back(item_row(KIND_STEP, 32'd0, 32'd65535));
    dir_rows.push_back(item_row(KIND_STEP, 32'd0, 32'd65536));
    dir_rows.push_back(item_row(KIND_STOP, 32'h5555_aaaa, 32'haaaa_5555));
    // Zero limit clamps drive and integral; zero window always clears
    dir_rows.push_back(cfg_row(CFG_OUT_LIMIT, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_INT_WINDOW, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_GAIN_P, 16'h8000));
    dir_rows.push_back(cfg_row(CFG_GAIN_I, 16'h7fff));
    dir_rows.push_back(cfg_row(CFG_GAIN_D, 16'h7fff));
    dir_rows.push_back(cfg_row(CFG_INVERT, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_DEADZONE, 16'h0000));
    dir_rows.push_back(typed_row(KIND_STEP, 32'd10, 32'd20, 1'b0));
    dir_rows.push_back(typed_row(KIND_STEP, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
    dir_rows.push_back(typed_row(KIND_STEP, 32'h8000_0000, 32'h7fff_ffff, 1'b0));
    // Smallest nonzero limit and window
    dir_rows.push_back(cfg_row(CFG_OUT_LIMIT, 16'h0001));
    dir_rows.push_back(cfg_row(CFG_INT_WINDOW, 16'h0001));
    dir_rows.push_back(cfg_row(CFG_DEADZONE, 16'h0003));
    dir_rows.push_back(item_row(KIND_STEP, 32'd0, 32'd0));
    dir_rows.push_back(item_row(KIND_STEP, 32'd5, 32'd2));
    dir_rows.push_back(item_row(KIND_STEP, 32'h8000_0000, 32'h8000_0003));
    dir_rows.push_back(item_row(KIND_STOP, 32'h0000_0000, 32'hffff_ffff));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_on <= 1'b1;
    gap_on = 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(dir_rows[k].reg_sel, dir_rows[k].value);
      end else begin
        send(dir_rows[k].kind, dir_rows[k].position, dir_rows[k].target,
             dir_rows[k].typed, dir_rows[k].want);
        busy = 1'b1;
      end
    end

    for (int p = 0; p < PHASES; p++) run_phase(PHASE_REQS, p == PHASES - 1);

    settle();
    if (errors == 0) $display("tb_position_pid_controller: done, clean");
    else $display("tb_position_pid_controller: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> position_pid_controller.f
design/ppc_pkg.sv
design/ppc_mac.sv
design/position_pid_controller.sv
dv/tb_position_pid_controller.sv
